@@ hdl/assert_macros.svh @@
// assertion macros for the rtl modules, included by the engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, checked only while out of reset
`define HSA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property, checked at every edge including reset
`define HSA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/hsa_pkg.sv @@
// types and constants of the handle slot allocator
package hsa_pkg;

  // command codes
  typedef enum logic [1:0] {
    CMD_SET_DEFAULT = 2'd0,
    CMD_REGISTER    = 2'd1,
    CMD_UNREGISTER  = 2'd2,
    CMD_LOOKUP      = 2'd3
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    STS_DONE     = 2'd0,
    STS_IGNORED  = 2'd1,
    STS_FULL     = 2'd2,
    STS_OVERFLOW = 2'd3
  } status_t;

  // engine sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_EXEC  = 2'd2
  } state_t;

  // configuration register indexes (paddr[3:2])
  localparam logic [1:0] REG_WHITE_SLOT  = 2'd0;
  localparam logic [1:0] REG_NORMAL_SLOT = 2'd1;
  localparam logic [1:0] REG_FIRST_FRESH = 2'd2;

  // configuration reset values
  localparam logic [9:0]  WHITE_RST  = 10'd0;
  localparam logic [9:0]  NORMAL_RST = 10'd1;
  localparam logic [10:0] FRESH_RST  = 11'd2;

  // request payload
  typedef struct packed {
    cmd_t        cmd;
    logic [9:0]  slot_index;
    logic        slot_valid;
    logic [31:0] texture_id;
  } req_t;

  // result payload
  typedef struct packed {
    logic [9:0]  handle_index;
    logic        handle_ok;
    logic [31:0] texture_out;
    logic [10:0] live_count;
    status_t     status;
  } resp_t;

  // configuration seen by the engine
  typedef struct packed {
    logic [9:0]  white_slot;
    logic [9:0]  normal_slot;
    logic [10:0] first_fresh_slot;
    logic        fresh_load;
  } cfg_t;

endpackage

@@ hdl/hsa_ram.sv @@
// generic single-write, single-read ram with registered read data
module hsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/hsa_engine.sv @@
// request sequencer and read-modify-write datapath over slot store and free stack
`include "assert_macros.svh"

module hsa_engine #(
  parameter int CAPACITY = 1024,
  parameter int ID_W     = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hsa_pkg::cfg_t                 cfg,
  input  logic                          start,
  input  hsa_pkg::req_t                 in_req,
  output logic                          busy,
  output logic                          out_valid,
  output hsa_pkg::resp_t                out_resp,
  // slot store ram
  output logic                          st_we,
  output logic [$clog2(CAPACITY)-1:0]   st_waddr,
  output logic [ID_W-1:0]               st_wdata,
  output logic                          st_re,
  output logic [$clog2(CAPACITY)-1:0]   st_raddr,
  input  logic [ID_W-1:0]               st_rdata,
  // free stack ram
  output logic                          sk_we,
  output logic [$clog2(CAPACITY)-1:0]   sk_waddr,
  output logic [$clog2(CAPACITY)-1:0]   sk_wdata,
  output logic                          sk_re,
  output logic [$clog2(CAPACITY)-1:0]   sk_raddr,
  input  logic [$clog2(CAPACITY)-1:0]   sk_rdata
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int FR_W  = (CNT_W > 11) ? CNT_W : 11;
  localparam bit ALL_IN = (CAPACITY >= 1024);
  localparam logic [9:0]       CAP10  = ALL_IN ? 10'd0 : 10'(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_C  = CNT_W'(CAPACITY);
  localparam logic [FR_W-1:0]  CAP_FR = FR_W'(CAPACITY);
  localparam logic [IDX_W-1:0] LAST   = IDX_W'(CAPACITY - 1);

  hsa_pkg::state_t      state_r, state_nxt;
  logic [IDX_W-1:0]     clr_r, clr_nxt;
  hsa_pkg::req_t        req_r;
  logic [CNT_W-1:0]     top_r, top_nxt;
  logic [FR_W-1:0]      fresh_r, fresh_nxt;
  logic [CNT_W-1:0]     occ_r, occ_nxt;
  logic                 out_valid_r;
  hsa_pkg::resp_t       out_resp_r, resp_nxt;
  logic                 accept;
  logic                 exec;

  // width adaptation helpers
  logic [IDX_W+9:0]     in_idx_wide;
  logic [IDX_W+9:0]     req_idx_wide;
  logic [IDX_W-1:0]     req_addr;
  logic [CNT_W-1:0]     top_dec;
  logic [FR_W+10:0]     ff_wide;
  logic [FR_W-1:0]      ff_ext;

  // decoded request fields and flags
  logic                 in_range;
  logic                 reserved;
  logic [ID_W-1:0]      tex;
  logic                 old_nz;
  logic [CNT_W-1:0]     occ_up;
  logic [CNT_W-1:0]     occ_dn;
  logic [IDX_W-1:0]     slot;
  logic [IDX_W+9:0]     slot_wide;
  logic [CNT_W+10:0]    occ_wide;
  logic [ID_W+31:0]     old_wide;

  assign in_idx_wide  = {{IDX_W{1'b0}}, in_req.slot_index};
  assign req_idx_wide = {{IDX_W{1'b0}}, req_r.slot_index};
  assign req_addr     = req_idx_wide[IDX_W-1:0];
  assign top_dec      = top_r - CNT_W'(1);
  assign ff_wide      = {{FR_W{1'b0}}, cfg.first_fresh_slot};
  assign ff_ext       = ff_wide[FR_W-1:0];
  assign old_wide     = {32'd0, st_rdata};

  // sequencer: clearing pass, idle, then an execute state for each request
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    busy      = 1'b1;
    unique case (state_r)
      hsa_pkg::ST_CLEAR: begin
        clr_nxt = clr_r + IDX_W'(1);
        if (clr_r == LAST) begin
          state_nxt = hsa_pkg::ST_IDLE;
        end
      end
      hsa_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_nxt = hsa_pkg::ST_EXEC;
        end
      end
      hsa_pkg::ST_EXEC: begin
        state_nxt = hsa_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = hsa_pkg::ST_CLEAR;
      end
    endcase
  end

  assign accept = start && !busy;
  assign exec   = (state_r == hsa_pkg::ST_EXEC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hsa_pkg::ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  // reads issued on accept, data ready in the execute cycle
  assign st_re    = accept;
  assign st_raddr = in_idx_wide[IDX_W-1:0];
  assign sk_re    = accept;
  assign sk_raddr = top_dec[IDX_W-1:0];

  // request flags
  assign in_range  = ALL_IN || (req_r.slot_index < CAP10);
  assign reserved  = (req_r.slot_index == cfg.white_slot) ||
                     (req_r.slot_index == cfg.normal_slot);
  assign tex       = req_r.texture_id[ID_W-1:0];
  assign old_nz    = |st_rdata;
  assign occ_up    = (occ_r < CAP_C) ? occ_r + CNT_W'(1) : occ_r;
  assign occ_dn    = (occ_r != '0) ? occ_r - CNT_W'(1) : occ_r;
  assign slot      = (top_r != '0) ? sk_rdata : fresh_r[IDX_W-1:0];
  assign slot_wide = {10'd0, slot};
  assign occ_wide  = {11'd0, occ_nxt};

  // clearing writes, and the read-modify-write of the execute cycle
  always_comb begin
    st_we     = 1'b0;
    st_waddr  = req_addr;
    st_wdata  = '0;
    sk_we     = 1'b0;
    sk_waddr  = top_r[IDX_W-1:0];
    sk_wdata  = req_addr;
    top_nxt   = top_r;
    fresh_nxt = fresh_r;
    occ_nxt   = occ_r;
    resp_nxt  = '0;
    resp_nxt.status = hsa_pkg::STS_DONE;

    if (state_r == hsa_pkg::ST_CLEAR) begin
      st_we    = 1'b1;
      st_waddr = clr_r;
    end else if (exec) begin
      unique case (req_r.cmd)
        hsa_pkg::CMD_SET_DEFAULT: begin
          if (!reserved || !in_range) begin
            resp_nxt.status = hsa_pkg::STS_IGNORED;
          end else begin
            st_we    = 1'b1;
            st_wdata = tex;
            if (!old_nz && (tex != '0)) begin
              occ_nxt = occ_up;
            end else if (old_nz && (tex == '0)) begin
              occ_nxt = occ_dn;
            end
          end
        end
        hsa_pkg::CMD_REGISTER: begin
          if (tex == '0) begin
            resp_nxt.status = hsa_pkg::STS_IGNORED;
          end else if ((top_r != '0) || (fresh_r < CAP_FR)) begin
            if (top_r != '0) begin
              top_nxt = top_dec;
            end else begin
              fresh_nxt = fresh_r + FR_W'(1);
            end
            st_we    = 1'b1;
            st_waddr = slot;
            st_wdata = tex;
            occ_nxt  = occ_up;
            resp_nxt.handle_index = slot_wide[9:0];
            resp_nxt.handle_ok    = 1'b1;
          end else begin
            resp_nxt.status = hsa_pkg::STS_FULL;
          end
        end
        hsa_pkg::CMD_UNREGISTER: begin
          if (!req_r.slot_valid || !in_range || reserved) begin
            resp_nxt.status = hsa_pkg::STS_IGNORED;
          end else begin
            st_we = 1'b1;
            if (top_r < CAP_C) begin
              sk_we   = 1'b1;
              top_nxt = top_r + CNT_W'(1);
            end else begin
              resp_nxt.status = hsa_pkg::STS_OVERFLOW;
            end
            occ_nxt = occ_dn;
          end
        end
        hsa_pkg::CMD_LOOKUP: begin
          if (!req_r.slot_valid || !in_range) begin
            resp_nxt.status = hsa_pkg::STS_IGNORED;
          end else begin
            resp_nxt.texture_out = old_wide[31:0];
          end
        end
        default: begin
          resp_nxt.status = hsa_pkg::STS_IGNORED;
        end
      endcase
    end

    // a write of first_fresh_slot reloads the bump counter
    if (cfg.fresh_load) begin
      fresh_nxt = ff_ext;
    end
    resp_nxt.live_count = occ_wide[10:0];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r       <= '0;
      fresh_r     <= FR_W'(hsa_pkg::FRESH_RST);
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      top_r       <= top_nxt;
      fresh_r     <= fresh_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= exec;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
    end
    if (exec) begin
      out_resp_r <= resp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_resp  = out_resp_r;

  // checks
  `HSA_ASSERT(a_exec_strobe, clk, rst_n, exec |=> out_valid_r, "result strobe missing after execute")
  `HSA_ASSERT(a_strobe_single, clk, rst_n, out_valid_r |=> !out_valid_r, "result strobe held two cycles")
  `HSA_ASSERT(a_top_bound, clk, rst_n, top_r <= CAP_C, "free stack top beyond capacity")
  `HSA_ASSERT(a_occ_bound, clk, rst_n, occ_r <= CAP_C, "live count beyond capacity")
  `HSA_ASSERT_ALWAYS(a_reset_busy, clk, !rst_n |=> busy, "block not busy after reset")

endmodule

@@ hdl/handle_slot_allocator_core.sv @@
// top level of the handle slot allocator: register port, memories and engine
//
//   channel   ports                          handshake
//   ------------------------------------------------------------------------
//   request   start, busy, in_req            taken when start && !busy
//   result    out_valid, out_resp            one-cycle strobe, no back-pressure
//   config    psel, penable, pwrite, paddr,  written in the access cycle,
//             pwdata, prdata, pready         pready always high
//
// a request first reads slot store and free stack on accept (the memories have
// registered read data), then modifies and writes back in the execute state; the
// result strobe follows in the next cycle, in which a new request can be taken.
// after reset the slot store is cleared one entry a cycle, over all CAPACITY
// entries, with busy high; configuration writes are taken during that pass.
// the result side has no stall; every result is presented once.
module handle_slot_allocator_core #(
  parameter int CAPACITY = 1024,
  parameter int ID_BITS  = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               start,
  output logic               busy,
  input  hsa_pkg::req_t      in_req,
  // result channel
  output logic               out_valid,
  output hsa_pkg::resp_t     out_resp,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // identifiers arrive 32 bits wide, so no more than 32 bits are kept
  localparam int ID_W  = (ID_BITS < 32) ? ID_BITS : 32;
  localparam int IDX_W = $clog2(CAPACITY);

  logic [9:0]   white_r;
  logic [9:0]   normal_r;
  logic [10:0]  fresh_cfg_r;
  logic         wr_en;
  logic [1:0]   reg_sel;
  hsa_pkg::cfg_t cfg;

  logic             st_we, st_re, sk_we, sk_re;
  logic [IDX_W-1:0] st_waddr, st_raddr, sk_waddr, sk_raddr;
  logic [ID_W-1:0]  st_wdata, st_rdata;
  logic [IDX_W-1:0] sk_wdata, sk_rdata;

  // register write decode
  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      white_r     <= hsa_pkg::WHITE_RST;
      normal_r    <= hsa_pkg::NORMAL_RST;
      fresh_cfg_r <= hsa_pkg::FRESH_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        hsa_pkg::REG_WHITE_SLOT:  white_r     <= pwdata[9:0];
        hsa_pkg::REG_NORMAL_SLOT: normal_r    <= pwdata[9:0];
        hsa_pkg::REG_FIRST_FRESH: fresh_cfg_r <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // register read mux
  always_comb begin
    unique case (reg_sel)
      hsa_pkg::REG_WHITE_SLOT:  prdata = {22'd0, white_r};
      hsa_pkg::REG_NORMAL_SLOT: prdata = {22'd0, normal_r};
      hsa_pkg::REG_FIRST_FRESH: prdata = {21'd0, fresh_cfg_r};
      default:                  prdata = 32'd0;
    endcase
  end

  // configuration to the engine; counter reload uses the written value
  assign cfg.white_slot       = white_r;
  assign cfg.normal_slot      = normal_r;
  assign cfg.first_fresh_slot = pwdata[10:0];
  assign cfg.fresh_load       = wr_en && (reg_sel == hsa_pkg::REG_FIRST_FRESH);

  hsa_engine #(
    .CAPACITY (CAPACITY),
    .ID_W     (ID_W)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .start     (start),
    .in_req    (in_req),
    .busy      (busy),
    .out_valid (out_valid),
    .out_resp  (out_resp),
    .st_we     (st_we),
    .st_waddr  (st_waddr),
    .st_wdata  (st_wdata),
    .st_re     (st_re),
    .st_raddr  (st_raddr),
    .st_rdata  (st_rdata),
    .sk_we     (sk_we),
    .sk_waddr  (sk_waddr),
    .sk_wdata  (sk_wdata),
    .sk_re     (sk_re),
    .sk_raddr  (sk_raddr),
    .sk_rdata  (sk_rdata)
  );

  // slot store: one identifier per slot
  hsa_ram #(
    .WIDTH (ID_W),
    .DEPTH (CAPACITY)
  ) u_slot_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // free stack of released slot indexes
  hsa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (CAPACITY)
  ) u_free_stack (
    .clk   (clk),
    .we    (sk_we),
    .waddr (sk_waddr),
    .wdata (sk_wdata),
    .re    (sk_re),
    .raddr (sk_raddr),
    .rdata (sk_rdata)
  );

endmodule

@@ sim/handle_slot_allocator_core_tb.sv @@
// self-checking testbench for the handle slot allocator: directed script, then random phases
module handle_slot_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY = 1024;
  localparam int CYCLE_LIMIT = 400000;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  hsa_pkg::req_t   in_req = '0;
  logic            out_valid;
  hsa_pkg::resp_t  out_resp;
  logic            psel = 1'b0;
  logic            penable = 1'b0;
  logic            pwrite = 1'b0;
  logic [3:0]      paddr = '0;
  logic [31:0]     pwdata = '0;
  logic [31:0]     prdata;
  logic            pready;

  handle_slot_allocator_core #(
    .CAPACITY(CAPACITY),
    .ID_BITS (32)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_resp (out_resp),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // shadow copy of the allocator state and its configuration
  logic [31:0] slot_ids   [CAPACITY] = '{default: '0};
  logic [9:0]  free_slots [CAPACITY] = '{default: '0};
  int          free_depth = 0;
  int          fresh_next = int'(hsa_pkg::FRESH_RST);
  int          live_slots = 0;
  logic [9:0]  cfg_white  = hsa_pkg::WHITE_RST;
  logic [9:0]  cfg_normal = hsa_pkg::NORMAL_RST;

  hsa_pkg::resp_t pending_results [$];
  logic [9:0]     issued [$];
  int             errors = 0;
  int             cycles = 0;

  // one directed step: a register write or a request, optionally with a typed result
  typedef struct {
    bit             is_write;
    logic [1:0]     reg_idx;
    logic [31:0]    reg_val;
    hsa_pkg::req_t  req;
    bit             typed;
    hsa_pkg::resp_t want;
  } step_t;

  step_t script [$];

  // random phase: sender idling, configuration, length, request mix
  typedef struct {
    int          idle_pct;
    logic [9:0]  white;
    logic [9:0]  normal;
    logic [10:0] fresh;
    int          count;
    int          reg_pct;
    bit          flood;
  } phase_t;

  phase_t phases [4] = '{
    '{0,  10'd0,    10'd1,    11'd0,    300,  35, 1'b0},
    '{78, 10'd1023, 10'd0,    11'd1000, 250,  60, 1'b0},
    '{22, 10'd512,  10'd513,  11'd700,  1100, 0,  1'b1},
    '{0,  10'd5,    10'd1023, 11'd1024, 250,  35, 1'b0}
  };

  // expected result of one request, updating the shadow state
  function automatic hsa_pkg::resp_t predict_slot_op(hsa_pkg::req_t r);
    hsa_pkg::resp_t o;
    logic [9:0]     slot;
    bit             got;
    bit             reserved;
    o = '0;
    o.status = hsa_pkg::STS_DONE;
    slot = '0;
    got = 1'b0;
    reserved = (r.slot_index == cfg_white) || (r.slot_index == cfg_normal);
    case (r.cmd)
      hsa_pkg::CMD_SET_DEFAULT: begin
        if (!reserved) begin
          o.status = hsa_pkg::STS_IGNORED;
        end else begin
          if (slot_ids[r.slot_index] == 0 && r.texture_id != 0) begin
            if (live_slots < CAPACITY) live_slots++;
          end else if (slot_ids[r.slot_index] != 0 && r.texture_id == 0) begin
            if (live_slots > 0) live_slots--;
          end
          slot_ids[r.slot_index] = r.texture_id;
        end
      end
      hsa_pkg::CMD_REGISTER: begin
        if (r.texture_id == 0) begin
          o.status = hsa_pkg::STS_IGNORED;
        end else if (free_depth > 0) begin
          free_depth--;
          slot = free_slots[free_depth];
          got = 1'b1;
        end else if (fresh_next < CAPACITY) begin
          slot = fresh_next[9:0];
          fresh_next++;
          got = 1'b1;
        end else begin
          o.status = hsa_pkg::STS_FULL;
        end
        if (got) begin
          slot_ids[slot] = r.texture_id;
          if (live_slots < CAPACITY) live_slots++;
          o.handle_index = slot;
          o.handle_ok = 1'b1;
        end
      end
      hsa_pkg::CMD_UNREGISTER: begin
        if (!r.slot_valid || reserved) begin
          o.status = hsa_pkg::STS_IGNORED;
        end else begin
          slot_ids[r.slot_index] = '0;
          if (free_depth < CAPACITY) begin
            free_slots[free_depth] = r.slot_index;
            free_depth++;
          end else begin
            o.status = hsa_pkg::STS_OVERFLOW;
          end
          if (live_slots > 0) live_slots--;
        end
      end
      default: begin
        if (!r.slot_valid) o.status = hsa_pkg::STS_IGNORED;
        else o.texture_out = slot_ids[r.slot_index];
      end
    endcase
    o.live_count = 11'(live_slots);
    return o;
  endfunction

  // random request; outside flood phases, unregister and lookup mostly aim at handles already given out
  function automatic hsa_pkg::req_t rand_request(int reg_pct, bit flood);
    hsa_pkg::req_t r;
    int            pick;
    int            k;
    r.slot_index = 10'($urandom_range(CAPACITY - 1));
    r.slot_valid = ($urandom_range(9) != 0);
    case ($urandom_range(9))
      0:       r.texture_id = '0;
      1:       r.texture_id = '1;
      default: r.texture_id = $urandom;
    endcase
    pick = $urandom_range(99);
    if (flood) begin
      r.cmd = (pick < 97) ? hsa_pkg::CMD_UNREGISTER : hsa_pkg::CMD_LOOKUP;
      r.slot_valid = 1'b1;
      return r;
    end
    if (pick < reg_pct) begin
      r.cmd = hsa_pkg::CMD_REGISTER;
    end else begin
      case ($urandom_range(5))
        0:       r.cmd = hsa_pkg::CMD_SET_DEFAULT;
        1, 2:    r.cmd = hsa_pkg::CMD_UNREGISTER;
        default: r.cmd = hsa_pkg::CMD_LOOKUP;
      endcase
    end
    case (r.cmd)
      hsa_pkg::CMD_SET_DEFAULT: begin
        if ($urandom_range(9) < 7) r.slot_index = $urandom_range(1) ? cfg_white : cfg_normal;
      end
      hsa_pkg::CMD_UNREGISTER, hsa_pkg::CMD_LOOKUP: begin
        if (issued.size() > 0 && $urandom_range(9) < 7) begin
          k = $urandom_range(issued.size() - 1);
          r.slot_index = issued[k];
          if (r.cmd == hsa_pkg::CMD_UNREGISTER) issued.delete(k);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void add_op(hsa_pkg::cmd_t c, int idx, bit v, logic [31:0] tex);
    step_t s;
    s = '{default: '0};
    s.req = '{cmd: c, slot_index: 10'(idx), slot_valid: v, texture_id: tex};
    script.push_back(s);
  endfunction

  function automatic void add_checked(hsa_pkg::cmd_t c, int idx, bit v, logic [31:0] tex,
                                      int hidx, bit ok, logic [31:0] tout, int live,
                                      hsa_pkg::status_t st);
    step_t s;
    s = '{default: '0};
    s.req = '{cmd: c, slot_index: 10'(idx), slot_valid: v, texture_id: tex};
    s.typed = 1'b1;
    s.want = '{handle_index: 10'(hidx), handle_ok: ok, texture_out: tout,
               live_count: 11'(live), status: st};
    script.push_back(s);
  endfunction

  function automatic void add_write(logic [1:0] idx, logic [31:0] val);
    step_t s;
    s = '{default: '0};
    s.is_write = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    script.push_back(s);
  endfunction

  // drive one request until taken, then record what it should produce
  task automatic issue_request(hsa_pkg::req_t r, bit typed, hsa_pkg::resp_t want);
    hsa_pkg::resp_t pred;
    start <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    pred = predict_slot_op(r);
    if (pred.handle_ok) issued.push_back(pred.handle_index);
    pending_results.push_back(typed ? want : pred);
  endtask

  // stop sending and let every pending result come back
  task automatic wait_drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // setup and access cycle on the register port
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      hsa_pkg::REG_WHITE_SLOT:  cfg_white = val[9:0];
      hsa_pkg::REG_NORMAL_SLOT: cfg_normal = val[9:0];
      hsa_pkg::REG_FIRST_FRESH: fresh_next = int'(val[10:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic void flag_field(string name, logic [31:0] want, logic [31:0] seen);
    errors++;
    $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, seen);
  endfunction

  // result checker: every strobe against the oldest pending result
  always @(posedge clk) begin : result_check
    hsa_pkg::resp_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual %p", $time, out_resp);
      end else begin
        want = pending_results.pop_front();
        if (out_resp.handle_index !== want.handle_index)
          flag_field("handle_index", 32'(want.handle_index), 32'(out_resp.handle_index));
        if (out_resp.handle_ok !== want.handle_ok)
          flag_field("handle_ok", 32'(want.handle_ok), 32'(out_resp.handle_ok));
        if (out_resp.texture_out !== want.texture_out)
          flag_field("texture_out", want.texture_out, out_resp.texture_out);
        if (out_resp.live_count !== want.live_count)
          flag_field("live_count", 32'(want.live_count), 32'(out_resp.live_count));
        if (out_resp.status !== want.status)
          flag_field("status", 32'(want.status), 32'(out_resp.status));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // stimulus
  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset state: empty slots, ignored requests, fresh slots from 2
    add_checked(hsa_pkg::CMD_LOOKUP, 5, 1'b1, 32'h5A5A_5A5A,
                0, 1'b0, 32'h0, 0, hsa_pkg::STS_DONE);
    add_checked(hsa_pkg::CMD_LOOKUP, 1023, 1'b0, 32'h0,
                0, 1'b0, 32'h0, 0, hsa_pkg::STS_IGNORED);
    add_checked(hsa_pkg::CMD_REGISTER, 0, 1'b0, 32'h0,
                0, 1'b0, 32'h0, 0, hsa_pkg::STS_IGNORED);
    add_checked(hsa_pkg::CMD_REGISTER, 1023, 1'b1, 32'hFFFF_FFFF,
                2, 1'b1, 32'h0, 1, hsa_pkg::STS_DONE);
    add_checked(hsa_pkg::CMD_REGISTER, 0, 1'b0, 32'h0000_0001,
                3, 1'b1, 32'h0, 2, hsa_pkg::STS_DONE);
    add_checked(hsa_pkg::CMD_LOOKUP, 2, 1'b1, 32'h0,
                0, 1'b0, 32'hFFFF_FFFF, 2, hsa_pkg::STS_DONE);
    // default slots and the live count
    add_checked(hsa_pkg::CMD_SET_DEFAULT, 0, 1'b0, 32'hA5A5_A5A5,
                0, 1'b0, 32'h0, 3, hsa_pkg::STS_DONE);
    add_checked(hsa_pkg::CMD_SET_DEFAULT, 1, 1'b1, 32'h0,
                0, 1'b0, 32'h0, 3, hsa_pkg::STS_DONE);
    add_checked(hsa_pkg::CMD_SET_DEFAULT, 5, 1'b1, 32'h7,
                0, 1'b0, 32'h0, 3, hsa_pkg::STS_IGNORED);
    add_checked(hsa_pkg::CMD_SET_DEFAULT, 0, 1'b1, 32'h0,
                0, 1'b0, 32'h0, 2, hsa_pkg::STS_DONE);
    add_checked(hsa_pkg::CMD_UNREGISTER, 0, 1'b1, 32'h0,
                0, 1'b0, 32'h0, 2, hsa_pkg::STS_IGNORED);
    add_checked(hsa_pkg::CMD_UNREGISTER, 2, 1'b0, 32'h0,
                0, 1'b0, 32'h0, 2, hsa_pkg::STS_IGNORED);
    // double free, free of an empty slot, count floor, lifo reuse
    add_op(hsa_pkg::CMD_UNREGISTER, 2, 1'b1, 32'h0);
    add_op(hsa_pkg::CMD_UNREGISTER, 2, 1'b1, 32'h0);
    add_op(hsa_pkg::CMD_UNREGISTER, 1023, 1'b1, 32'h0);
    add_op(hsa_pkg::CMD_REGISTER, 0, 1'b0, 32'h1234_5678);
    add_op(hsa_pkg::CMD_REGISTER, 0, 1'b0, 32'h8000_0000);
    add_op(hsa_pkg::CMD_REGISTER, 0, 1'b0, 32'h0000_0001);
    add_op(hsa_pkg::CMD_LOOKUP, 1023, 1'b1, 32'h0);
    add_op(hsa_pkg::CMD_REGISTER, 0, 1'b0, 32'h0000_0005);
    // fresh counter runs over a reserved slot, then the heap is full
    add_write(hsa_pkg::REG_WHITE_SLOT, 32'd1023);
    add_write(hsa_pkg::REG_NORMAL_SLOT, 32'd512);
    add_write(hsa_pkg::REG_FIRST_FRESH, 32'd1022);
    add_op(hsa_pkg::CMD_REGISTER, 0, 1'b0, 32'h9);
    add_op(hsa_pkg::CMD_REGISTER, 0, 1'b0, 32'h9);
    add_checked(hsa_pkg::CMD_REGISTER, 0, 1'b0, 32'h9,
                0, 1'b0, 32'h0, 6, hsa_pkg::STS_FULL);
    add_op(hsa_pkg::CMD_SET_DEFAULT, 1023, 1'b1, 32'h0);
    add_op(hsa_pkg::CMD_UNREGISTER, 512, 1'b1, 32'h0);
    add_op(hsa_pkg::CMD_SET_DEFAULT, 512, 1'b1, 32'h3);
    add_write(hsa_pkg::REG_FIRST_FRESH, 32'd1024);
    add_checked(hsa_pkg::CMD_REGISTER, 0, 1'b0, 32'h4,
                0, 1'b0, 32'h0, 6, hsa_pkg::STS_FULL);

    foreach (script[i]) begin
      if (script[i].is_write) begin
        wait_drain();
        write_reg(script[i].reg_idx, script[i].reg_val);
      end else begin
        issue_request(script[i].req, script[i].typed, script[i].want);
      end
    end

    // random phases, each under its own configuration and idling
    foreach (phases[p]) begin
      wait_drain();
      write_reg(hsa_pkg::REG_WHITE_SLOT, 32'(phases[p].white));
      write_reg(hsa_pkg::REG_NORMAL_SLOT, 32'(phases[p].normal));
      write_reg(hsa_pkg::REG_FIRST_FRESH, 32'(phases[p].fresh));
      for (int n = 0; n < phases[p].count; n++) begin
        if ($urandom_range(149) == 0) wait_drain();
        while ($urandom_range(99) < phases[p].idle_pct) begin
          start <= 1'b0;
          @(posedge clk);
        end
        issue_request(rand_request(phases[p].reg_pct, phases[p].flood), 1'b0, '0);
      end
    end

    wait_drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
